// ----- rtl/rmdd_pkg.sv -----
// Package for the running mean drift detector: widths, item kinds, status codes
// and the command type passed from front to back. No dependencies.
package rmdd_pkg;

    localparam int FEAT_COUNT = 16;
    localparam int FW = (FEAT_COUNT > 1) ? $clog2(FEAT_COUNT) : 1;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_CHECK  = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_LOAD   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_NO_DRIFT = 2'd0,
        ST_DRIFT    = 2'd1,
        ST_MISMATCH = 2'd2
    } status_t;

    // Command from the front part to the back part
    typedef struct packed {
        kind_t       kind;
        logic        mismatch;
        logic        first;
        logic [FW-1:0] pos;
        logic [31:0] value;
        logic [3:0]  slot;
        logic [31:0] dev;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] score;
        logic [3:0]  worst;
        logic        found;
    } res_t;

endpackage

// ----- rtl/rmdd_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module rmdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/rmdd_front.sv -----
// Front part: accepts items, tracks feature position and classifies checks.
// Depends on rmdd_pkg.
module rmdd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     in_kind,
    input  logic [31:0]    in_value,
    input  logic [3:0]     in_slot,
    input  logic [31:0]    in_dev,
    output logic           q_push,
    output rmdd_pkg::cmd_t q_cmd,
    input  logic           q_full
);
    import rmdd_pkg::*;

    logic [FW-1:0] pos_reg, pos_next;
    logic          acc;

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;
    assign q_push   = acc;

    // Build the command
    always_comb begin
        q_cmd.kind     = kind_t'(in_kind);
        q_cmd.mismatch = (pos_reg != '0);
        q_cmd.first    = (pos_reg == '0);
        q_cmd.pos      = pos_reg;
        q_cmd.value    = in_value;
        q_cmd.slot     = in_slot;
        q_cmd.dev      = in_dev;
    end

    // Advance or rewind the position
    always_comb begin
        pos_next = pos_reg;
        if (acc) begin
            case (kind_t'(in_kind))
                KIND_SAMPLE: pos_next = (pos_reg == FW'(FEAT_COUNT - 1)) ? '0
                                                                        : pos_reg + 1'b1;
                KIND_CHECK:  pos_next = '0;
                KIND_CLEAR:  pos_next = '0;
                default:     pos_next = pos_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end
endmodule

// ----- rtl/rmdd_queue.sv -----
// Short command queue between front and back parts.
// Depends on rmdd_pkg.
module rmdd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rmdd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output rmdd_pkg::cmd_t head
);
    import rmdd_pkg::*;
    localparam int AW = $clog2(QDEPTH);

    cmd_t            slots_reg [QDEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slots_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wp_reg] <= push_cmd;
        end
    end

    // Hold pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ----- rtl/rmdd_divider.sv -----
// Restoring divider, one quotient bit a cycle, unsigned 48 by 32 bits.
// No dependencies.
module rmdd_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    logic [47:0] q_reg;
    logic [32:0] r_reg;
    logic [31:0] d_reg;
    logic [5:0]  n_reg;
    logic        busy_reg;
    logic [32:0] trial;
    logic [33:0] sub;

    assign trial    = {r_reg[31:0], q_reg[47]};
    assign sub      = {1'b0, trial} - {2'b0, d_reg};
    assign quotient = q_reg;
    assign done     = busy_reg && (n_reg == 6'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            n_reg    <= 6'd48;
            q_reg    <= dividend;
            r_reg    <= '0;
            d_reg    <= divisor;
        end else if (busy_reg && n_reg != 6'd0) begin
            n_reg <= n_reg - 1'b1;
            if (!sub[33]) begin
                r_reg <= sub[32:0];
                q_reg <= {q_reg[46:0], 1'b1};
            end else begin
                r_reg <= trial;
                q_reg <= {q_reg[46:0], 1'b0};
            end
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end
endmodule

// ----- rtl/rmdd_back.sv -----
// Back part: updates running means, loads baselines, clears means and walks features on a check.
// Depends on rmdd_pkg, rmdd_ram and rmdd_divider.
module rmdd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [31:0]    threshold,
    input  logic           q_empty,
    input  rmdd_pkg::cmd_t q_head,
    output logic           q_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output rmdd_pkg::res_t res
);
    import rmdd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SREAD, S_SDIV, S_CHK_RD, S_CHK_WAIT, S_CHK_DIV, S_OUT, S_CLR
    } state_t;

    state_t        state_reg;
    cmd_t          cmd_reg;
    logic [FEAT_COUNT-1:0] valid_reg;
    logic [FEAT_COUNT-1:0] bvalid_reg;
    logic [31:0]   count_reg;
    logic [FW-1:0] idx_reg;
    logic [31:0]   best_reg;
    logic [3:0]    worst_reg;
    logic          found_reg;
    logic          neg_reg;
    logic [31:0]   mean_reg;
    logic          outv_reg;
    res_t          out_reg;

    // Memories
    logic          rm_we, bm_we;
    logic [FW-1:0] rm_wa, rm_ra, bm_ra;
    logic [31:0]   rm_wd, rm_rd, bm_rd, bs_rd;

    rmdd_ram #(.WIDTH(32), .DEPTH(FEAT_COUNT)) u_rm (
        .aclk(aclk), .we(rm_we), .waddr(rm_wa), .wdata(rm_wd),
        .raddr(rm_ra), .rdata(rm_rd));
    rmdd_ram #(.WIDTH(32), .DEPTH(FEAT_COUNT)) u_bm (
        .aclk(aclk), .we(bm_we), .waddr(cmd_reg.slot[FW-1:0]),
        .wdata(cmd_reg.value), .raddr(bm_ra), .rdata(bm_rd));
    rmdd_ram #(.WIDTH(32), .DEPTH(FEAT_COUNT)) u_bs (
        .aclk(aclk), .we(bm_we), .waddr(cmd_reg.slot[FW-1:0]),
        .wdata(cmd_reg.dev), .raddr(bm_ra), .rdata(bs_rd));

    // Divider
    logic        dv_start, dv_done;
    logic [47:0] dv_n, dv_q;
    logic [31:0] dv_d;
    rmdd_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .dividend(dv_n),
        .divisor(dv_d), .done(dv_done), .quotient(dv_q));

    logic [31:0] cnt_eff, mean_v, bl_v, base_v, dev_v;
    logic signed [32:0] diff_s, dd_s;
    logic [32:0] mag;
    logic [31:0] z, qtrunc;
    logic [47:0] qsigned;
    logic        slot_ok;

    assign slot_ok = ({28'd0, q_head.slot} < 32'(FEAT_COUNT));
    assign mean_v  = valid_reg[cmd_reg.pos] ? rm_rd : 32'd0;
    assign bl_v    = valid_reg[idx_reg] ? rm_rd : 32'd0;
    // Baseline entries never loaded read as zero
    assign base_v  = bvalid_reg[idx_reg] ? bm_rd : 32'd0;
    assign dev_v   = bvalid_reg[idx_reg] ? bs_rd : 32'd0;
    assign cnt_eff = (count_reg == 32'd0) ? 32'd1 : count_reg;
    assign diff_s  = $signed({cmd_reg.value[31], cmd_reg.value})
                   - $signed({mean_v[31], mean_v});
    assign dd_s    = $signed({bl_v[31], bl_v}) - $signed({base_v[31], base_v});
    assign mag     = dd_s[32] ? 33'(-dd_s) : 33'(dd_s);
    assign z       = (dv_q[47:32] != 16'd0) ? 32'hFFFF_FFFF : dv_q[31:0];
    assign qsigned = neg_reg ? 48'(-dv_q) : dv_q;
    assign qtrunc  = qsigned[31:0];

    assign q_pop     = (state_reg == S_IDLE) && !q_empty && !outv_reg
                    || (state_reg == S_IDLE) && !q_empty && q_head.kind != KIND_CHECK;
    assign res_valid = outv_reg;
    assign res       = out_reg;

    // Drive memory and divider control
    always_comb begin
        rm_we    = 1'b0;
        rm_wa    = cmd_reg.pos;
        rm_wd    = mean_reg + qtrunc;
        rm_ra    = (state_reg == S_IDLE) ? q_head.pos : idx_reg;
        bm_ra    = idx_reg;
        bm_we    = (state_reg == S_CLR);
        dv_start = 1'b0;
        dv_n     = '0;
        dv_d     = cnt_eff;
        if (state_reg == S_SREAD) begin
            dv_start = 1'b1;
            dv_n     = {15'd0, diff_s[32] ? 33'(-diff_s) : 33'(diff_s)};
        end
        if (state_reg == S_SDIV && dv_done) begin
            rm_we = 1'b1;
        end
        if (state_reg == S_CHK_WAIT) begin
            dv_start = (dev_v != 32'd0);
            dv_n     = {mag[31:0], 16'd0};
            dv_d     = dev_v;
        end
    end

    // Sequence one command at a time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            bvalid_reg <= '0;
            count_reg  <= '0;
            outv_reg   <= 1'b0;
        end else begin
            if (outv_reg && res_ready) outv_reg <= 1'b0;
            if (rm_we) valid_reg[rm_wa] <= 1'b1;
            if (bm_we) bvalid_reg[cmd_reg.slot[FW-1:0]] <= 1'b1;
            case (state_reg)
                S_IDLE: if (q_pop) begin
                    cmd_reg <= q_head;
                    case (q_head.kind)
                        KIND_SAMPLE: begin
                            if (q_head.first && count_reg != 32'hFFFF_FFFF)
                                count_reg <= count_reg + 1'b1;
                            state_reg <= S_SREAD;
                        end
                        KIND_CLEAR: begin
                            valid_reg <= '0;
                            count_reg <= '0;
                        end
                        KIND_LOAD: if (slot_ok) state_reg <= S_CLR;
                        KIND_CHECK: begin
                            if (q_head.mismatch) begin
                                outv_reg      <= 1'b1;
                                out_reg       <= '{ST_MISMATCH, 32'd0, 4'd0, 1'b0};
                            end else begin
                                idx_reg   <= '0;
                                best_reg  <= '0;
                                worst_reg <= '0;
                                found_reg <= 1'b0;
                                state_reg <= S_CHK_RD;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SREAD: begin
                    mean_reg  <= mean_v;
                    neg_reg   <= diff_s[32];
                    state_reg <= S_SDIV;
                end
                S_SDIV: if (dv_done) state_reg <= S_IDLE;
                S_CLR: state_reg <= S_IDLE;
                S_CHK_RD: state_reg <= S_CHK_WAIT;
                S_CHK_WAIT: state_reg <= (dev_v != 32'd0) ? S_CHK_DIV : S_OUT;
                S_CHK_DIV: if (dv_done) begin
                    if (!found_reg || z > best_reg) begin
                        best_reg  <= z;
                        worst_reg <= 4'(idx_reg);
                        found_reg <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (idx_reg == FW'(FEAT_COUNT - 1)) begin
                        outv_reg  <= 1'b1;
                        out_reg   <= '{(found_reg && best_reg > threshold) ? ST_DRIFT
                                       : ST_NO_DRIFT, best_reg, worst_reg, found_reg};
                        state_reg <= S_IDLE;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_CHK_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.kind == KIND_CLEAR) |=> (count_reg == 32'd0))
        else $error("count not cleared");
    a_mismatch_res: assert property (@(posedge aclk) disable iff (!aresetn)
        (outv_reg && out_reg.status == ST_MISMATCH) |-> (out_reg.score == 32'd0))
        else $error("mismatch with score");
    a_drift_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (outv_reg && out_reg.status == ST_DRIFT) |-> out_reg.found)
        else $error("drift without feature");
`endif
endmodule

// ----- rtl/running_mean_drift_detector.sv -----
// Top level of the running mean drift detector: config register and wiring.
// Depends on rmdd_pkg, rmdd_front, rmdd_queue, rmdd_back.
//
//  channel   | direction | handshake            | payload
//  s_axis    | in        | s_tvalid / s_tready  | kind, sample_value, feature_slot, dev
//  m_axis    | out       | m_tvalid / m_tready  | status, peak_score, worst_feature, found
//  cfg       | in        | cfg_valid / cfg_ready| drift_threshold
//
// A sample occupies the back part through S_SREAD and S_SDIV, where it waits for the
// one-bit-a-cycle divider (48 steps); a load passes through S_CLR and a clear is done
// in S_IDLE. A check walks each feature through S_CHK_RD and S_CHK_WAIT, then S_CHK_DIV
// for a nonzero deviation, then S_OUT; a length mismatch check is answered from S_IDLE.
// Reset is synchronous, active low. The two-entry queue lets the input keep
// accepting while a result waits, until it holds two items.
module running_mean_drift_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // kind
    input  logic [71:0] s_tdata,   // sample_value[31:0], feature_slot[35:32],
                                   // baseline_deviation[67:36], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // status
    output logic [39:0] m_tdata,   // peak_score[31:0], worst_feature[35:32],
                                   // worst_found[36], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import rmdd_pkg::*;

    logic [31:0] thr_reg;
    logic        push, full, empty, pop;
    cmd_t        pcmd, head;
    res_t        res;

    assign cfg_ready = 1'b1;

    // Hold the threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 32'd196608;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    rmdd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_kind(s_tuser), .in_value(s_tdata[31:0]), .in_slot(s_tdata[35:32]),
        .in_dev(s_tdata[67:36]), .q_push(push), .q_cmd(pcmd), .q_full(full));

    rmdd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_cmd(pcmd), .full(full),
        .pop(pop), .empty(empty), .head(head));

    rmdd_back u_back (
        .aclk(aclk), .aresetn(aresetn), .threshold(thr_reg), .q_empty(empty),
        .q_head(head), .q_pop(pop), .res_valid(m_tvalid), .res_ready(m_tready),
        .res(res));

    assign m_tuser = res.status;
    assign m_tdata = {3'd0, res.found, res.worst, res.score};
endmodule
